[rtl/cgs_pkg.sv]
package cgs_pkg;

   localparam int MAX_STOPS  = 4;
   localparam int STOP_IDX_W = $clog2(MAX_STOPS);
   localparam int CNT_W      = 3;
   localparam int T_W        = 17;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 4;
   localparam int RGBA_W     = CH_W * NUM_CH;
   localparam int WORD_W     = T_W + RGBA_W;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_W      = CH_W + T_W;
   localparam int DIV_STEPS  = CH_W;

   localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_STOP_BASE  = CSR_IDX_W'(1);

   // one channel's work handed to the divide lane
   typedef struct packed {
      logic [CH_W-1:0]  ca;
      logic             neg;
      logic [NUM_W-1:0] num;
      logic [T_W-1:0]   span;
   } lane_in_type;

endpackage

[rtl/cgs_ifs.sv]
interface cgs_req_if;
   logic                     valid;
   logic                     ready;
   logic [cgs_pkg::T_W-1:0]  age_fraction;

   modport source (output valid, output age_fraction, input ready);
   modport sink   (input valid, input age_fraction, output ready);
endinterface

interface cgs_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [cgs_pkg::CH_W-1:0] red;
   logic [cgs_pkg::CH_W-1:0] green;
   logic [cgs_pkg::CH_W-1:0] blue;
   logic [cgs_pkg::CH_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

[rtl/cgs_lerp_lane.sv]
// One channel: restoring divide, one quotient bit per stage, then ca +/- q.
module cgs_lerp_lane (
   input  logic                        clock,
   input  logic                        advance,
   input  cgs_pkg::lane_in_type        lane_in,
   output logic [cgs_pkg::CH_W-1:0]    color
);

   logic [cgs_pkg::NUM_W-1:0]     rem_ff  [cgs_pkg::DIV_STEPS];
   logic [cgs_pkg::CH_W-1:0]      quo_ff  [cgs_pkg::DIV_STEPS];
   logic [cgs_pkg::CH_W-1:0]      ca_ff   [cgs_pkg::DIV_STEPS];
   logic                          neg_ff  [cgs_pkg::DIV_STEPS];
   logic [cgs_pkg::T_W-1:0]       span_ff [cgs_pkg::DIV_STEPS];
   logic [cgs_pkg::CH_W-1:0]      color_ff;
   logic [cgs_pkg::CH_W-1:0]      color_in;

   for (genvar j = 0; j < cgs_pkg::DIV_STEPS; j++) begin : g_step
      logic [cgs_pkg::NUM_W-1:0] rem_src;
      logic [cgs_pkg::CH_W-1:0]  quo_src;
      logic [cgs_pkg::CH_W-1:0]  ca_src;
      logic                      neg_src;
      logic [cgs_pkg::T_W-1:0]   span_src;
      logic [cgs_pkg::NUM_W-1:0] trial;
      logic [cgs_pkg::NUM_W-1:0] rem_in;
      logic [cgs_pkg::CH_W-1:0]  quo_in;

      if (j == 0) begin : g_first
         assign rem_src  = lane_in.num;
         assign quo_src  = '0;
         assign ca_src   = lane_in.ca;
         assign neg_src  = lane_in.neg;
         assign span_src = lane_in.span;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign ca_src   = ca_ff[j-1];
         assign neg_src  = neg_ff[j-1];
         assign span_src = span_ff[j-1];
      end

      // divisor aligned to quotient bit (DIV_STEPS-1-j)
      assign trial = cgs_pkg::NUM_W'(span_src) << (cgs_pkg::DIV_STEPS - 1 - j);

      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            quo_in[cgs_pkg::DIV_STEPS-1-j] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            ca_ff[j]   <= ca_src;
            neg_ff[j]  <= neg_src;
            span_ff[j] <= span_src;
         end
      end
   end

   // q never exceeds |cb - ca|, so the result stays in 0..255
   assign color_in = neg_ff[cgs_pkg::DIV_STEPS-1]
                   ? ca_ff[cgs_pkg::DIV_STEPS-1] - quo_ff[cgs_pkg::DIV_STEPS-1]
                   : ca_ff[cgs_pkg::DIV_STEPS-1] + quo_ff[cgs_pkg::DIV_STEPS-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

[rtl/color_gradient_sampler_core.sv]
// Piecewise linear RGBA8 color ramp. Each req transaction carries an age in
// unsigned Q1.16 (saturated to 1.0); each rsp transaction returns the color
// sampled from up to four stops held in the csr registers, or a white fade
// with alpha 255 down to 0 when stop_count is 0. Throughput is one
// transaction per clock unless rsp stalls. The 13 register stages are key
// compare, segment select, span/delta, multiply, eight divide stages (one
// quotient bit each, four channel lanes side by side) and the output
// register. The whole pipe holds while a result waits at the output, so
// req_if.ready is low only while rsp is stalled with a valid result. The
// user must write registers only while the pipe is empty; nothing checks it.
module color_gradient_sampler_core (
   input  logic                               clock,
   input  logic                               reset,
   cgs_req_if.sink                            req_if,
   cgs_rsp_if.source                          rsp_if,
   input  logic                               csr_wr_en,
   input  logic [cgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cgs_pkg::WORD_W-1:0]         csr_wdata
);

   localparam int PIPE_DEPTH = 4 + cgs_pkg::DIV_STEPS + 1;

   // ---------------------------------------------------------------- csr
   logic [cgs_pkg::CNT_W-1:0]  stop_count_ff;
   logic [cgs_pkg::T_W-1:0]    stop_key_ff  [cgs_pkg::MAX_STOPS];
   logic [cgs_pkg::RGBA_W-1:0] stop_rgba_ff [cgs_pkg::MAX_STOPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         for (int i = 0; i < cgs_pkg::MAX_STOPS; i++) begin
            stop_key_ff[i]  <= '0;
            stop_rgba_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index == cgs_pkg::REG_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[cgs_pkg::CNT_W-1:0];
         end
         for (int i = 0; i < cgs_pkg::MAX_STOPS; i++) begin
            if (csr_index == cgs_pkg::REG_STOP_BASE + cgs_pkg::CSR_IDX_W'(i)) begin
               stop_key_ff[i]  <= csr_wdata[cgs_pkg::WORD_W-1:cgs_pkg::RGBA_W];
               stop_rgba_ff[i] <= csr_wdata[cgs_pkg::RGBA_W-1:0];
            end
         end
      end
   end

   // ---------------------------------------------------------- flow control
   // One valid bit per stage; every stage moves together.
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;
   logic                  advance;
   logic                  req_take;

   assign advance      = !vld_ff[PIPE_DEPTH-1] || rsp_if.ready;
   assign req_if.ready = advance;
   assign req_take     = req_if.valid && advance;
   assign vld_in       = {vld_ff[PIPE_DEPTH-2:0], req_take};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------ stage 1: key compares
   logic [cgs_pkg::T_W-1:0]       t_sat;
   logic [cgs_pkg::CNT_W-1:0]     cnt_sat;
   logic [cgs_pkg::T_W-1:0]       s1_t_ff;
   logic [cgs_pkg::CNT_W-1:0]     s1_cnt_ff;
   logic [cgs_pkg::MAX_STOPS-1:0] s1_lt_ff;
   logic [cgs_pkg::MAX_STOPS-1:0] s1_eq_ff;

   assign t_sat   = (req_if.age_fraction > cgs_pkg::ONE_Q16) ? cgs_pkg::ONE_Q16
                                                             : req_if.age_fraction;
   assign cnt_sat = (stop_count_ff > cgs_pkg::CNT_W'(cgs_pkg::MAX_STOPS))
                  ? cgs_pkg::CNT_W'(cgs_pkg::MAX_STOPS) : stop_count_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_t_ff   <= t_sat;
         s1_cnt_ff <= cnt_sat;
         for (int i = 0; i < cgs_pkg::MAX_STOPS; i++) begin
            s1_lt_ff[i] <= t_sat < stop_key_ff[i];
            s1_eq_ff[i] <= t_sat == stop_key_ff[i];
         end
      end
   end

   // --------------------------------------------- stage 2: segment select
   logic [cgs_pkg::MAX_STOPS-1:0]  le;
   logic [cgs_pkg::STOP_IDX_W-1:0] last_idx;
   logic [cgs_pkg::STOP_IDX_W-1:0] lo_idx;
   logic [cgs_pkg::STOP_IDX_W-1:0] pair_idx;
   logic                           pair_found;
   logic                           is_flat;
   logic                           is_fade;
   logic [cgs_pkg::T_W-1:0]        s2_t_ff;
   logic [cgs_pkg::T_W-1:0]        s2_ka_ff;
   logic [cgs_pkg::T_W-1:0]        s2_kb_ff;
   logic [cgs_pkg::RGBA_W-1:0]     s2_ca_ff;
   logic [cgs_pkg::RGBA_W-1:0]     s2_cb_ff;
   logic                           s2_flat_ff;
   logic [cgs_pkg::T_W-1:0]        ka_sel;
   logic [cgs_pkg::T_W-1:0]        kb_sel;
   logic [cgs_pkg::RGBA_W-1:0]     ca_sel;
   logic [cgs_pkg::RGBA_W-1:0]     cb_sel;

   assign le       = s1_lt_ff | s1_eq_ff;
   assign last_idx = cgs_pkg::STOP_IDX_W'(s1_cnt_ff - cgs_pkg::CNT_W'(1));

   always_comb begin
      pair_found = 1'b0;
      pair_idx   = '0;
      for (int i = 0; i < cgs_pkg::MAX_STOPS - 1; i++) begin
         if (!pair_found && (i + 1 < int'(s1_cnt_ff)) && le[i+1]) begin
            pair_found = 1'b1;
            pair_idx   = cgs_pkg::STOP_IDX_W'(i);
         end
      end
   end

   always_comb begin
      is_fade = 1'b0;
      is_flat = 1'b1;
      lo_idx  = last_idx;
      if (s1_cnt_ff == '0) begin
         is_fade = 1'b1;
         is_flat = 1'b0;
      end else if (s1_cnt_ff == cgs_pkg::CNT_W'(1) || le[0]) begin
         lo_idx = '0;
      end else if (!s1_lt_ff[last_idx]) begin
         lo_idx = last_idx;
      end else if (pair_found) begin
         // t lies above the lower key and at or below the upper key of some segment
         is_flat = 1'b0;
         lo_idx  = pair_idx;
      end
   end

   always_comb begin
      ka_sel = stop_key_ff[lo_idx];
      ca_sel = stop_rgba_ff[lo_idx];
      kb_sel = stop_key_ff[lo_idx + cgs_pkg::STOP_IDX_W'(1)];
      cb_sel = stop_rgba_ff[lo_idx + cgs_pkg::STOP_IDX_W'(1)];
      if (is_fade) begin
         // opaque white to transparent white over 0..1.0
         ka_sel = '0;
         kb_sel = cgs_pkg::ONE_Q16;
         ca_sel = '1;
         cb_sel = {{(cgs_pkg::RGBA_W - cgs_pkg::CH_W){1'b1}}, {cgs_pkg::CH_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_t_ff    <= s1_t_ff;
         s2_ka_ff   <= ka_sel;
         s2_kb_ff   <= kb_sel;
         s2_ca_ff   <= ca_sel;
         s2_cb_ff   <= cb_sel;
         s2_flat_ff <= is_flat;
      end
   end

   // ----------------------------------------- stage 3: span, delta, diffs
   // A flat segment (end clamp or zero/descending span) becomes q = 0.
   logic                        flat;
   logic [cgs_pkg::T_W-1:0]     s3_d_ff;
   logic [cgs_pkg::T_W-1:0]     s3_span_ff;
   logic [cgs_pkg::CH_W-1:0]    s3_ca_ff  [cgs_pkg::NUM_CH];
   logic [cgs_pkg::CH_W-1:0]    s3_mag_ff [cgs_pkg::NUM_CH];
   logic                        s3_neg_ff [cgs_pkg::NUM_CH];
   logic [cgs_pkg::CH_W-1:0]    ch_a      [cgs_pkg::NUM_CH];
   logic [cgs_pkg::CH_W:0]      ch_diff   [cgs_pkg::NUM_CH];
   logic [cgs_pkg::CH_W:0]      ch_abs    [cgs_pkg::NUM_CH];

   assign flat = s2_flat_ff || (s2_kb_ff <= s2_ka_ff);

   always_comb begin
      for (int c = 0; c < cgs_pkg::NUM_CH; c++) begin
         // channel 0 is red in the top byte
         ch_a[c]    = s2_ca_ff[cgs_pkg::RGBA_W - 1 - cgs_pkg::CH_W*c -: cgs_pkg::CH_W];
         ch_diff[c] = {1'b0, s2_cb_ff[cgs_pkg::RGBA_W - 1 - cgs_pkg::CH_W*c -: cgs_pkg::CH_W]}
                    - {1'b0, ch_a[c]};
         ch_abs[c]  = ch_diff[c][cgs_pkg::CH_W] ? -ch_diff[c] : ch_diff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_d_ff    <= flat ? '0 : s2_t_ff - s2_ka_ff;
         s3_span_ff <= flat ? cgs_pkg::T_W'(1) : s2_kb_ff - s2_ka_ff;
         for (int c = 0; c < cgs_pkg::NUM_CH; c++) begin
            s3_ca_ff[c]  <= ch_a[c];
            s3_neg_ff[c] <= ch_diff[c][cgs_pkg::CH_W];
            s3_mag_ff[c] <= flat ? '0 : ch_abs[c][cgs_pkg::CH_W-1:0];
         end
      end
   end

   // ---------------------------------------------- stage 4: |diff| * d
   cgs_pkg::lane_in_type s4_lane_ff [cgs_pkg::NUM_CH];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < cgs_pkg::NUM_CH; c++) begin
            s4_lane_ff[c].ca   <= s3_ca_ff[c];
            s4_lane_ff[c].neg  <= s3_neg_ff[c];
            s4_lane_ff[c].num  <= cgs_pkg::NUM_W'(s3_mag_ff[c]) * cgs_pkg::NUM_W'(s3_d_ff);
            s4_lane_ff[c].span <= s3_span_ff;
         end
      end
   end

   // ------------------------------------------ divide lanes + output reg
   logic [cgs_pkg::CH_W-1:0] lane_color [cgs_pkg::NUM_CH];

   for (genvar c = 0; c < cgs_pkg::NUM_CH; c++) begin : g_lane
      cgs_lerp_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .lane_in (s4_lane_ff[c]),
         .color   (lane_color[c])
      );
   end

   assign rsp_if.valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_if.red   = lane_color[0];
   assign rsp_if.green = lane_color[1];
   assign rsp_if.blue  = lane_color[2];
   assign rsp_if.alpha = lane_color[3];

   // ------------------------------------------------------------ checks
   // an accepted transaction occupies the first stage next cycle
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[0])
      else $error("accepted transaction missing from first stage");

   // a stall at the output freezes every valid bit
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> $stable(vld_ff))
      else $error("pipe moved during output stall");

   // input is refused only while a result waits at the output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready)
      else $error("input refused without output stall");

endmodule
